// File: sv/mhb_pkg.sv
// Shared types and constants of the multidimensional histogram binner.
package mhb_pkg;

	typedef enum logic [1:0] {
		OP_FEED  = 2'd0,
		OP_QUERY = 2'd1,
		OP_PRUNE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_LOW_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS    = 3'd6;

	localparam int COORD_W  = 16;
	localparam int INDEX_W  = 9;
	localparam int THRESH_W = 24;
	localparam int BCOUNT_W = 24;
	localparam int TOTAL_W  = 32;
	localparam int PRUNED_W = 10;
	localparam int BINS_W   = 4;
	localparam int AXES     = 3;

	typedef struct packed {
		op_t                        op;
		logic signed [COORD_W-1:0]  coord_0;
		logic signed [COORD_W-1:0]  coord_1;
		logic signed [COORD_W-1:0]  coord_2;
		logic        [INDEX_W-1:0]  query_bin;
		logic        [THRESH_W-1:0] threshold;
	} cmd_t;

	typedef struct packed {
		logic [INDEX_W-1:0]  bin_index;
		logic [BCOUNT_W-1:0] bin_count;
		logic [TOTAL_W-1:0]  total_count;
		logic [PRUNED_W-1:0] pruned_bins;
	} result_t;

	// one operand set for the shared quantizer
	typedef struct packed {
		logic                      issue;
		logic signed [COORD_W-1:0] coord;
		logic signed [COORD_W-1:0] low_edge;
		logic        [COORD_W-1:0] scale;
	} quant_req_t;

endpackage

// File: sv/mhb_ram.sv
// Generic simple dual-port RAM with registered read data.
module mhb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/mhb_quant.sv
// Shared quantizer: subtract, multiply by scale, register, then clamp to a bin digit.
module mhb_quant #(
	parameter int MAX_STEPS = 8,
	localparam int DW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mhb_pkg::quant_req_t req,
	input  logic [DW-1:0]       bins_m1,
	output logic                vld,
	output logic [DW-1:0]       digit
);

	import mhb_pkg::*;

	logic signed [COORD_W:0]     diff;
	logic                        zero;
	logic [2*COORD_W-1:0]        prod;
	logic                        vld_s1;
	logic                        zero_s1;
	logic [2*COORD_W-1:0]        prod_s1;
	logic [2*COORD_W-9:0]        qval;

	always_comb begin
		diff = {req.coord[COORD_W-1], req.coord} - {req.low_edge[COORD_W-1], req.low_edge};
		zero = diff[COORD_W] || (diff == '0) || (req.scale == '0);
		prod = diff[COORD_W-1:0] * req.scale;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.issue;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= zero;
		prod_s1 <= prod;
	end

	// drop the eight fraction bits, then clamp to the last bin
	always_comb begin
		qval = prod_s1[2*COORD_W-1:8];
		if (zero_s1) begin
			digit = '0;
		end else if (qval > (2*COORD_W-8)'(bins_m1)) begin
			digit = bins_m1;
		end else begin
			digit = DW'(qval);
		end
		vld = vld_s1;
	end

endmodule

// File: sv/multidim_histogram_binner.sv
// Histogram binner top level: sequencer, configuration registers and bin store.
//
// One command at a time: start is taken when busy is low, and done pulses for one
// cycle with the result, which the receiver must take then. A feed uses one shared
// quantizer (one multiplier) once per dimension, then a read-modify-write of the
// bin store. A query makes one store read; a prune walks all MAX_STEPS**DIMS bins,
// one bin per cycle through the store's read and write ports; an unused op gives
// done in the cycle after it is taken. A new command may start in the cycle done
// is high. After reset the store is cleared by a pass over all MAX_STEPS**DIMS
// bins with busy high; configuration writes are taken always.
module multidim_histogram_binner #(
	parameter int DIMS       = 3,
	parameter int MAX_STEPS  = 8,
	parameter int COUNT_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  mhb_pkg::cmd_t                       cmd,
	output logic                                done,
	output mhb_pkg::result_t                    result,
	input  logic                                cfg_we,
	input  logic [mhb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mhb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	import mhb_pkg::*;

	localparam int DEPTH = MAX_STEPS ** DIMS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int DIM_W = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_QUANT, S_QLAST, S_FUPD, S_QRESP, S_PRUNE, S_PDRAIN
	} state_t;

	state_t                    state_q;
	cmd_t                      cmd_q;
	logic                      in_range_q;
	logic [DIM_W-1:0]          dim_q;
	logic [AW-1:0]             pos_q;
	logic [AW-1:0]             walk_q;
	logic [TOTAL_W-1:0]        total_q;
	logic [PRUNED_W-1:0]       pruned_q;
	logic                      pv_s1;
	logic [AW-1:0]             pa_s1;
	result_t                   res_q;
	logic                      done_q;

	logic signed [COORD_W-1:0] low_q   [AXES];
	logic        [COORD_W-1:0] scale_q [AXES];
	logic        [BINS_W-1:0]  bins_q;
	logic signed [COORD_W-1:0] coord_a [AXES];
	logic        [DW-1:0]      bins_m1;

	quant_req_t                qreq;
	logic                      q_vld;
	logic [DW-1:0]             q_digit;
	logic [AW-1:0]             pos_next;

	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [COUNT_BITS-1:0]     ram_wdata;
	logic [AW-1:0]             ram_raddr;
	logic [COUNT_BITS-1:0]     ram_rdata;

	logic [COUNT_BITS-1:0]     cnt_inc;
	logic [TOTAL_W-1:0]        cnt_ext;
	logic                      hit;
	logic [TOTAL_W-1:0]        total_pruned;
	logic [PRUNED_W-1:0]       pruned_next;
	logic [TOTAL_W-1:0]        total_inc;
	logic                      accept;
	logic                      done_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q[0]   <= '0;
			low_q[1]   <= '0;
			low_q[2]   <= '0;
			scale_q[0] <= 16'd256;
			scale_q[1] <= 16'd256;
			scale_q[2] <= 16'd256;
			bins_q     <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOW_X:   low_q[0]   <= cfg_wdata;
				CFG_LOW_Y:   low_q[1]   <= cfg_wdata;
				CFG_LOW_Z:   low_q[2]   <= cfg_wdata;
				CFG_SCALE_X: scale_q[0] <= cfg_wdata;
				CFG_SCALE_Y: scale_q[1] <= cfg_wdata;
				CFG_SCALE_Z: scale_q[2] <= cfg_wdata;
				CFG_BINS:    bins_q     <= cfg_wdata[BINS_W-1:0];
				default:     ;
			endcase
		end
	end

	// zero bins act as one, too many as MAX_STEPS
	always_comb begin
		if (bins_q == '0) begin
			bins_m1 = '0;
		end else if (32'(bins_q) > MAX_STEPS) begin
			bins_m1 = DW'(MAX_STEPS - 1);
		end else begin
			bins_m1 = DW'(bins_q - 1'b1);
		end
	end

	always_comb begin
		coord_a[0]    = cmd_q.coord_0;
		coord_a[1]    = cmd_q.coord_1;
		coord_a[2]    = cmd_q.coord_2;
		qreq.issue    = (state_q == S_QUANT);
		qreq.coord    = coord_a[dim_q];
		qreq.low_edge = low_q[dim_q];
		qreq.scale    = scale_q[dim_q];
	end

	mhb_quant #(.MAX_STEPS(MAX_STEPS)) u_quant (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (qreq),
		.bins_m1 (bins_m1),
		.vld     (q_vld),
		.digit   (q_digit)
	);

	// dimension 0 ends up most significant
	assign pos_next = AW'(32'(pos_q) * MAX_STEPS) + AW'(q_digit);

	always_comb begin
		cnt_inc      = (ram_rdata < COUNT_MAX) ? ram_rdata + COUNT_BITS'(1) : ram_rdata;
		cnt_ext      = TOTAL_W'(ram_rdata);
		total_inc    = (total_q != '1) ? total_q + 1'b1 : total_q;
		hit          = pv_s1 && (cnt_ext != '0) && (cnt_ext < TOTAL_W'(cmd_q.threshold));
		total_pruned = total_q;
		pruned_next  = pruned_q;
		if (hit) begin
			total_pruned = (total_q >= cnt_ext) ? total_q - cnt_ext : '0;
			pruned_next  = pruned_q + 1'b1;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pa_s1;
		ram_wdata = '0;
		ram_raddr = AW'(cmd.query_bin);
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = walk_q;
			end
			S_QLAST: ram_raddr = pos_next;
			S_FUPD: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = cnt_inc;
			end
			S_PRUNE: begin
				ram_raddr = walk_q;
				ram_we    = hit;
			end
			S_PDRAIN: ram_we = hit;
			default: ;
		endcase
	end

	mhb_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept = start && (state_q == S_IDLE);

	assign done_next = (state_q == S_FUPD) || (state_q == S_QRESP) || (state_q == S_PDRAIN)
		|| (accept && (cmd.op == OP_NONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			cmd_q      <= '0;
			in_range_q <= 1'b0;
			dim_q      <= '0;
			pos_q      <= '0;
			walk_q     <= '0;
			total_q    <= '0;
			pruned_q   <= '0;
			pv_s1      <= 1'b0;
			pa_s1      <= '0;
			res_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= done_next;
			pv_s1  <= (state_q == S_PRUNE);
			case (state_q)
				S_CLEAR: begin
					if (walk_q == AW'(DEPTH - 1)) begin
						walk_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q      <= cmd;
						in_range_q <= (32'(cmd.query_bin) < DEPTH);
						dim_q      <= '0;
						pos_q      <= '0;
						walk_q     <= '0;
						pruned_q   <= '0;
						case (cmd.op)
							OP_FEED:  state_q <= S_QUANT;
							OP_QUERY: state_q <= S_QRESP;
							OP_PRUNE: state_q <= S_PRUNE;
							default: begin
								res_q.bin_index   <= '0;
								res_q.bin_count   <= '0;
								res_q.total_count <= total_q;
								res_q.pruned_bins <= '0;
							end
						endcase
					end
				end
				S_QUANT: begin
					if (q_vld) begin
						pos_q <= pos_next;
					end
					if (dim_q == DIM_W'(DIMS - 1)) begin
						state_q <= S_QLAST;
					end else begin
						dim_q <= dim_q + 1'b1;
					end
				end
				S_QLAST: begin
					pos_q   <= pos_next;
					state_q <= S_FUPD;
				end
				S_FUPD: begin
					total_q           <= total_inc;
					res_q.bin_index   <= INDEX_W'(pos_q);
					res_q.bin_count   <= BCOUNT_W'(cnt_inc);
					res_q.total_count <= total_inc;
					res_q.pruned_bins <= '0;
					state_q           <= S_IDLE;
				end
				S_QRESP: begin
					res_q.bin_index   <= cmd_q.query_bin;
					res_q.bin_count   <= in_range_q ? BCOUNT_W'(ram_rdata) : '0;
					res_q.total_count <= total_q;
					res_q.pruned_bins <= '0;
					state_q           <= S_IDLE;
				end
				S_PRUNE: begin
					// read one bin ahead, clear the one read last cycle if it is under the threshold
					total_q  <= total_pruned;
					pruned_q <= pruned_next;
					pa_s1    <= walk_q;
					walk_q   <= walk_q + 1'b1;
					if (walk_q == AW'(DEPTH - 1)) begin
						state_q <= S_PDRAIN;
					end
				end
				S_PDRAIN: begin
					total_q           <= total_pruned;
					pruned_q          <= pruned_next;
					res_q.bin_index   <= '0;
					res_q.bin_count   <= '0;
					res_q.total_count <= total_pruned;
					res_q.pruned_bins <= pruned_next;
					state_q           <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the multidimensional histogram binner.
`timescale 1ns / 100ps

module testbench;

	import mhb_pkg::*;

	localparam int STEPS        = 8;
	localparam int STORE_DEPTH  = STEPS * STEPS * STEPS;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 600;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 210;
	localparam int ROW_SLOTS    = 32;
	localparam int WANT_SLOTS   = 8;

	typedef struct packed {
		cmd_t    c;
		logic    typed;
		result_t res;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	cmd_t                  cmd;
	logic                  done;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// shadow of the histogram and its settings
	bit [BCOUNT_W-1:0]         model_bins [STORE_DEPTH];
	bit [TOTAL_W-1:0]          model_total;
	logic signed [COORD_W-1:0] low_cfg [AXES];
	bit [COORD_W-1:0]          scale_cfg [AXES];
	bit [BINS_W-1:0]           bins_cfg;

	// results still owed by the block, oldest at want_rd
	result_t            want_fifo [WANT_SLOTS];
	int                 want_wr;
	int                 want_rd;
	dir_row_t           dir_rows [ROW_SLOTS];
	int                 dir_count;
	bit                 failed;
	int                 stall_cycles;
	logic [INDEX_W-1:0] last_fed;

	multidim_histogram_binner i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int bins_in_use();
		if (bins_cfg == 0)
			return 1;
		if (bins_cfg > STEPS)
			return STEPS;
		return int'(bins_cfg);
	endfunction

	function automatic int axis_bin(logic signed [COORD_W-1:0] coord, int d);
		int     diff;
		longint q;
		diff = int'(coord) - int'(low_cfg[d]);
		if (diff <= 0 || scale_cfg[d] == 0)
			return 0;
		q = (longint'(diff) * longint'(scale_cfg[d])) >>> 8;
		if (q >= bins_in_use())
			q = longint'(bins_in_use() - 1);
		return int'(q);
	endfunction

	function automatic result_t histogram_apply(cmd_t c);
		result_t r;
		int      pos;
		r = '0;
		case (c.op)
			OP_FEED: begin
				pos = (axis_bin(c.coord_0, 0) * STEPS + axis_bin(c.coord_1, 1)) * STEPS
					+ axis_bin(c.coord_2, 2);
				if (model_bins[pos] != '1)
					model_bins[pos] = model_bins[pos] + 1'b1;
				if (model_total != '1)
					model_total = model_total + 1'b1;
				r.bin_index = INDEX_W'(pos);
				r.bin_count = model_bins[pos];
			end
			OP_QUERY: begin
				r.bin_index = c.query_bin;
				r.bin_count = model_bins[c.query_bin];
			end
			OP_PRUNE: begin
				for (int i = 0; i < STORE_DEPTH; i++) begin
					if (model_bins[i] != 0 && model_bins[i] < c.threshold) begin
						r.pruned_bins = r.pruned_bins + 1'b1;
						model_total = (model_total >= model_bins[i]) ?
							model_total - model_bins[i] : '0;
						model_bins[i] = '0;
					end
				end
			end
			default: ;
		endcase
		r.total_count = model_total;
		return r;
	endfunction

	function automatic void add_row(op_t op, int c0, int c1, int c2, int qb, int thr,
			bit typed, int ei, int ec, int et, int ep);
		dir_row_t row;
		row.c.op          = op;
		row.c.coord_0     = COORD_W'(c0);
		row.c.coord_1     = COORD_W'(c1);
		row.c.coord_2     = COORD_W'(c2);
		row.c.query_bin   = INDEX_W'(qb);
		row.c.threshold   = THRESH_W'(thr);
		row.typed         = typed;
		row.res.bin_index   = INDEX_W'(ei);
		row.res.bin_count   = BCOUNT_W'(ec);
		row.res.total_count = TOTAL_W'(et);
		row.res.pruned_bins = PRUNED_W'(ep);
		dir_rows[dir_count] = row;
		dir_count = dir_count + 1;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(int d);
		int span;
		int v;
		if ($urandom_range(0, 4) == 0)
			return COORD_W'($urandom);
		// aim around the low edge so that every bin and both clamps get hit
		span = (scale_cfg[d] == 0) ? 64 : ((bins_in_use() + 1) * 256) / scale_cfg[d] + 1;
		v = int'(low_cfg[d]) - span / 8 + int'($urandom_range(0, span));
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return COORD_W'(v);
	endfunction

	function automatic logic [COORD_W-1:0] pick_scale();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return COORD_W'($urandom_range(16, 2048));
		endcase
	endfunction

	task automatic send_cmd(cmd_t c, bit typed, result_t typed_res);
		result_t r;
		@(negedge clk);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		r = histogram_apply(c);
		if (c.op == OP_FEED)
			last_fed = r.bin_index;
		if (typed)
			r = typed_res;
		want_fifo[want_wr % WANT_SLOTS] = r;
		want_wr = want_wr + 1;
	endtask

	task automatic idle_gap(int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (want_wr != want_rd)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_LOW_X:   low_cfg[0]   = val;
			CFG_LOW_Y:   low_cfg[1]   = val;
			CFG_LOW_Z:   low_cfg[2]   = val;
			CFG_SCALE_X: scale_cfg[0] = val;
			CFG_SCALE_Y: scale_cfg[1] = val;
			CFG_SCALE_Z: scale_cfg[2] = val;
			CFG_BINS:    bins_cfg     = val[BINS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_phase(int p);
		logic [COORD_W-1:0] lo [AXES];
		logic [COORD_W-1:0] sc [AXES];
		logic [BINS_W-1:0]  nb;
		case (p)
			0: begin
				lo = '{16'h0000, 16'h0000, 16'h0000};
				sc = '{16'h0100, 16'h0100, 16'h0100};
				nb = 4'd8;
			end
			1: begin
				lo = '{16'h8000, 16'h8000, 16'h8000};
				sc = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
				nb = 4'd0;
			end
			2: begin
				lo = '{16'h7FFF, 16'h8000, 16'h0000};
				sc = '{16'h0000, 16'h0001, 16'hFFFF};
				nb = 4'd15;
			end
			default: begin
				for (int d = 0; d < AXES; d++) begin
					lo[d] = $urandom_range(0, 1) ? COORD_W'($urandom) :
						COORD_W'(int'($urandom_range(0, 2047)) - 1024);
					sc[d] = pick_scale();
				end
				nb = BINS_W'($urandom_range(0, 15));
			end
		endcase
		write_reg(CFG_LOW_X, lo[0]);
		write_reg(CFG_LOW_Y, lo[1]);
		write_reg(CFG_LOW_Z, lo[2]);
		write_reg(CFG_SCALE_X, sc[0]);
		write_reg(CFG_SCALE_Y, sc[1]);
		write_reg(CFG_SCALE_Z, sc[2]);
		// junk in the upper bits must not leak into the bin count
		write_reg(CFG_BINS, {12'($urandom_range(0, 4095)), nb});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random(bit allow_gaps);
		cmd_t c;
		int   r;
		if (allow_gaps && $urandom_range(0, 4) == 0)
			idle_gap($urandom_range(1, 8));
		c.coord_0   = COORD_W'($urandom);
		c.coord_1   = COORD_W'($urandom);
		c.coord_2   = COORD_W'($urandom);
		c.query_bin = INDEX_W'($urandom);
		c.threshold = THRESH_W'($urandom);
		r = $urandom_range(0, 99);
		if (r < 68) begin
			c.op      = OP_FEED;
			c.coord_0 = pick_coord(0);
			c.coord_1 = pick_coord(1);
			c.coord_2 = pick_coord(2);
		end else if (r < 92) begin
			c.op = OP_QUERY;
			if ($urandom_range(0, 1))
				c.query_bin = last_fed;
		end else if (r < 96) begin
			c.op = OP_PRUNE;
			if ($urandom_range(0, 2) != 0)
				c.threshold = THRESH_W'($urandom_range(0, 6));
		end else begin
			c.op = OP_NONE;
		end
		send_cmd(c, 1'b0, '0);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && done) begin
			if (want_wr == want_rd) begin
				$display("%0t: result with no command waiting, expected none, got %p",
					$time, result);
				failed = 1'b1;
			end else begin
				want = want_fifo[want_rd % WANT_SLOTS];
				want_rd = want_rd + 1;
				check_field("bin_index", want.bin_index, result.bin_index);
				check_field("bin_count", want.bin_count, result.bin_count);
				check_field("total_count", want.total_count, result.total_count);
				check_field("pruned_bins", want.pruned_bins, result.pruned_bins);
			end
		end
	end

	// hang detector: no beat taken and no result for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		failed    = 1'b0;
		last_fed  = '0;
		want_wr   = 0;
		want_rd   = 0;
		dir_count = 0;
		foreach (model_bins[i])
			model_bins[i] = '0;
		model_total = '0;
		low_cfg     = '{16'h0000, 16'h0000, 16'h0000};
		scale_cfg   = '{16'h0100, 16'h0100, 16'h0100};
		bins_cfg    = 4'd8;

		// reset settings: unit scale, eight bins, edges at zero
		add_row(OP_QUERY, -1, -1, -1, 0, 'hFFFFFF, 1, 0, 0, 0, 0);
		add_row(OP_QUERY, 0, 0, 0, 511, 0, 1, 511, 0, 0, 0);
		add_row(OP_NONE, -1, -1, -1, 511, 'hFFFFFF, 1, 0, 0, 0, 0);
		add_row(OP_FEED, 0, 0, 0, 511, 'hFFFFFF, 1, 0, 1, 1, 0);
		add_row(OP_FEED, -32768, -32768, -32768, 0, 0, 1, 0, 2, 2, 0);
		add_row(OP_FEED, 32767, 32767, 32767, 0, 0, 1, 511, 1, 3, 0);
		add_row(OP_FEED, 1, 2, 3, 511, 'hFFFFFF, 1, 83, 1, 4, 0);
		add_row(OP_FEED, 8, -1, 7, 0, 0, 1, 455, 1, 5, 0);
		add_row(OP_QUERY, -1, -1, -1, 83, 'hFFFFFF, 1, 83, 1, 5, 0);
		add_row(OP_PRUNE, -1, -1, -1, 511, 0, 1, 0, 0, 5, 0);
		add_row(OP_PRUNE, 0, 0, 0, 0, 2, 1, 0, 0, 2, 3);
		add_row(OP_QUERY, 0, 0, 0, 511, 0, 1, 511, 0, 2, 0);
		add_row(OP_QUERY, 0, 0, 0, 0, 0, 1, 0, 2, 2, 0);
		add_row(OP_FEED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_PRUNE, -1, -1, -1, 511, 'hFFFFFF, 1, 0, 0, 0, 1);
		add_row(OP_FEED, 5, 6, 7, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_QUERY, 0, 0, 0, 375, 0, 0, 0, 0, 0, 0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < dir_count; i++)
			send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].res);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_phase(p);
			repeat (PHASE_ITEMS)
				send_random(p != PHASES - 1);
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: multidim_histogram_binner.f
sv/mhb_pkg.sv
sv/mhb_ram.sv
sv/mhb_quant.sv
sv/multidim_histogram_binner.sv
tb/sv/testbench.sv
